@@ design/btnq_pkg.sv @@
`default_nettype none

package btnq_pkg;

    // fixed field widths
    localparam int THRESH_W = 20;
    localparam int MASK_W   = 17;
    localparam int DIR_W    = 4;
    localparam int FUNC_W   = 3;
    localparam int BTN_W    = 5;
    localparam int AXIS_W   = 8;

    // default sizing
    localparam int DEF_NUM_BUTTONS = 17;
    localparam int DEF_COUNT_BITS  = 32;

    // repeat window, in thresholds
    localparam int REPEAT_START  = 20;
    localparam int REPEAT_PERIOD = 8;
    localparam int START_W       = THRESH_W + $clog2(REPEAT_START);
    localparam int PERIOD_W      = THRESH_W + $clog2(REPEAT_PERIOD);
    // remainder register holds one more bit than the divisor
    localparam int REM_W         = PERIOD_W + 1;

    // item codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRESS   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_AXIS_X  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_AXIS_Y  = 3'd4;

    // direction buttons
    localparam int BTN_UP    = 13;
    localparam int BTN_DOWN  = 14;
    localparam int BTN_LEFT  = 15;
    localparam int BTN_RIGHT = 16;

    // axis dead zone
    localparam logic signed [AXIS_W-1:0] AXIS_POS_LIMIT = 8'sd25;
    localparam logic signed [AXIS_W-1:0] AXIS_NEG_LIMIT = -8'sd25;

    // keypad direction codes
    localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd6;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd7;
    localparam logic [DIR_W-1:0] DIR_UP         = 4'd8;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd9;

    // held state of the four direction buttons
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } dpad_t;

endpackage

`default_nettype wire

@@ design/btnq_rem_unit.sv @@
`default_nettype none

module btnq_rem_unit
    import btnq_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [COUNT_BITS-1:0] dividend,
    input  wire logic [PERIOD_W-1:0]   divisor,
    output logic                       done,
    output logic [REM_W-1:0]           rem
);

    localparam int STEP_W = $clog2(COUNT_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [COUNT_BITS-1:0] shift_reg, shift_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      rem_step;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial    = {rem_reg[REM_W-2:0], shift_reg[COUNT_BITS-1]};
        rem_step = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
    end

    // step sequencing
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = rem_step;
            shift_next = {shift_reg[COUNT_BITS-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(COUNT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ design/btnq_dir.sv @@
`default_nettype none

module btnq_dir
    import btnq_pkg::*;
(
    input  wire dpad_t            pad,
    output logic [DIR_W-1:0]      dir_four,
    output logic [DIR_W-1:0]      dir_eight
);

    // four-way code, up first, then down, left, right
    always_comb
    begin
        priority if (pad.up)
            dir_four = DIR_UP;
        else if (pad.down)
            dir_four = DIR_DOWN;
        else if (pad.left)
            dir_four = DIR_LEFT;
        else if (pad.right)
            dir_four = DIR_RIGHT;
        else
            dir_four = DIR_NONE;
    end

    // eight-way code, left wins over right
    always_comb
    begin
        priority if (pad.up)
            dir_eight = pad.left ? DIR_UP_LEFT : (pad.right ? DIR_UP_RIGHT : DIR_UP);
        else if (pad.down)
            dir_eight = pad.left ? DIR_DOWN_LEFT : (pad.right ? DIR_DOWN_RIGHT : DIR_DOWN);
        else if (pad.left)
            dir_eight = DIR_LEFT;
        else if (pad.right)
            dir_eight = DIR_RIGHT;
        else
            dir_eight = DIR_NONE;
    end

endmodule

`default_nettype wire

@@ design/button_edge_repeat_qualifier_core.sv @@
// Button edge and auto-repeat qualifier. Keeps a held bit and a saturating
// tick counter per virtual button and, for every input beat (tick, press,
// release, X or Y axis sample), returns one output beat with the pressed,
// trigger, repeat and released masks plus four- and eight-way keypad codes.
// The block works on one beat at a time and stalls its input meanwhile: it
// applies the event in the idle state, then sweeps one button per cycle in
// the scan state while no division is running, then posts the result in the
// done state once the output is free. A held button whose count has reached
// 20 thresholds also runs the shared remainder unit, bit-serial at one bit
// per cycle, and the sweep waits in the divide state until it is done. The
// user must write hold_threshold through the cfg port only while the block
// is idle; the block does not enforce this. The cfg port never stalls.
`default_nettype none

module button_edge_repeat_qualifier_core
    import btnq_pkg::*;
#(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [FUNC_W-1:0]        func,
    input  wire logic [BTN_W-1:0]         button,
    input  wire logic signed [AXIS_W-1:0] axis_value,
    // output channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [MASK_W-1:0]             pressed_mask,
    output logic [MASK_W-1:0]             trigger_mask,
    output logic [MASK_W-1:0]             repeat_mask,
    output logic [MASK_W-1:0]             released_mask,
    output logic [DIR_W-1:0]              dir_four,
    output logic [DIR_W-1:0]              dir_eight,
    // configuration channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [THRESH_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(NUM_BUTTONS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [COUNT_BITS-1:0]  cnt_reg  [NUM_BUTTONS];
    logic [COUNT_BITS-1:0]  cnt_next [NUM_BUTTONS];
    logic [THRESH_W-1:0]    thresh_reg;
    logic [START_W-1:0]     start_reg;
    logic                   tick_reg, tick_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    logic [MASK_W-1:0] acc_pm_reg, acc_pm_next;
    logic [MASK_W-1:0] acc_tm_reg, acc_tm_next;
    logic [MASK_W-1:0] acc_rm_reg, acc_rm_next;
    logic [MASK_W-1:0] acc_fm_reg, acc_fm_next;

    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] out_pm_reg, out_tm_reg, out_rm_reg, out_fm_reg;
    logic [DIR_W-1:0]  out_d4_reg, out_d8_reg;

    logic                   accept;
    logic                   out_free;
    logic [NUM_BUTTONS-1:0] set_vec, clr_vec, change;
    logic [COUNT_BITS-1:0]  e_cur, e_upd;
    logic                   cur_held;
    logic                   below_t;
    logic                   in_mask;
    logic                   need_div;
    logic [MASK_W-1:0]      bit_sel;
    logic                   last_idx;
    logic                   div_done;
    logic [REM_W-1:0]       div_rem;
    logic [PERIOD_W-1:0]    divisor;
    dpad_t                  pad;
    logic [DIR_W-1:0]       dir4_w, dir8_w;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // decode the event into buttons to press and release
    always_comb
    begin
        set_vec = '0;
        clr_vec = '0;
        unique case (func)
            FUNC_PRESS:
            begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    if ({1'b0, button} == (BTN_W + 1)'(b))
                        set_vec[b] = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    if ({1'b0, button} == (BTN_W + 1)'(b))
                        clr_vec[b] = 1'b1;
                end
            end
            FUNC_AXIS_X:
            begin
                if (axis_value < AXIS_NEG_LIMIT)
                    set_vec[BTN_LEFT] = 1'b1;
                else if (axis_value > AXIS_POS_LIMIT)
                    set_vec[BTN_RIGHT] = 1'b1;
                else
                begin
                    clr_vec[BTN_LEFT]  = 1'b1;
                    clr_vec[BTN_RIGHT] = 1'b1;
                end
            end
            FUNC_AXIS_Y:
            begin
                if (axis_value < AXIS_NEG_LIMIT)
                    set_vec[BTN_UP] = 1'b1;
                else if (axis_value > AXIS_POS_LIMIT)
                    set_vec[BTN_DOWN] = 1'b1;
                else
                begin
                    clr_vec[BTN_UP]   = 1'b1;
                    clr_vec[BTN_DOWN] = 1'b1;
                end
            end
            default:
            begin
                set_vec = '0;
                clr_vec = '0;
            end
        endcase
        change = (set_vec & ~held_reg) | (clr_vec & held_reg);
    end

    // evaluate the button under the sweep pointer
    always_comb
    begin
        e_cur    = cnt_reg[idx_reg];
        e_upd    = (tick_reg && (e_cur != '1)) ? e_cur + 1'b1 : e_cur;
        cur_held = held_reg[idx_reg];
        below_t  = e_upd < COUNT_BITS'(thresh_reg);
        in_mask  = {1'b0, idx_reg} < (IDX_W + 1)'(MASK_W);
        need_div = cur_held && in_mask && (thresh_reg != '0)
                   && (e_upd >= COUNT_BITS'(start_reg));
        bit_sel  = MASK_W'(1'b1) << idx_reg;
        last_idx = idx_reg == IDX_W'(NUM_BUTTONS - 1);
        divisor  = PERIOD_W'(thresh_reg) * PERIOD_W'(REPEAT_PERIOD);
    end

    // counter updates: restart on a change, advance on the sweep
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            cnt_next[b] = cnt_reg[b];
            if (accept && change[b])
                cnt_next[b] = '0;
            else if ((state_reg == ST_SCAN) && (idx_reg == IDX_W'(b)))
                cnt_next[b] = e_upd;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        tick_next   = tick_reg;
        idx_next    = idx_reg;
        acc_pm_next = acc_pm_reg;
        acc_tm_next = acc_tm_reg;
        acc_rm_next = acc_rm_reg;
        acc_fm_next = acc_fm_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    held_next   = held_reg ^ change;
                    tick_next   = func == FUNC_TICK;
                    idx_next    = '0;
                    acc_pm_next = '0;
                    acc_tm_next = '0;
                    acc_rm_next = '0;
                    acc_fm_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cur_held)
                    acc_pm_next = acc_pm_reg | bit_sel;
                if (cur_held && below_t)
                    acc_tm_next = acc_tm_reg | bit_sel;
                if (!cur_held && below_t)
                    acc_fm_next = acc_fm_reg | bit_sel;
                if (need_div)
                    state_next = ST_DIV;
                else
                begin
                    if (cur_held && below_t)
                        acc_rm_next = acc_rm_reg | bit_sel;
                    if (last_idx)
                        state_next = ST_DONE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem < REM_W'(thresh_reg))
                        acc_rm_next = acc_rm_reg | bit_sel;
                    if (last_idx)
                        state_next = ST_DONE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // output beat handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_DONE) && out_free)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            tick_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= THRESH_W'(1);
            start_reg     <= START_W'(REPEAT_START);
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                cnt_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                cnt_reg[b] <= cnt_next[b];
            end
            if (cfg_valid)
            begin
                thresh_reg <= cfg_data;
                start_reg  <= START_W'(cfg_data) * START_W'(REPEAT_START);
            end
        end
    end

    // mask accumulators and output payload
    always_ff @(posedge clk)
    begin
        acc_pm_reg <= acc_pm_next;
        acc_tm_reg <= acc_tm_next;
        acc_rm_reg <= acc_rm_next;
        acc_fm_reg <= acc_fm_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_pm_reg <= acc_pm_reg;
            out_tm_reg <= acc_tm_reg;
            out_rm_reg <= acc_rm_reg;
            out_fm_reg <= acc_fm_reg;
            out_d4_reg <= dir4_w;
            out_d8_reg <= dir8_w;
        end
    end

    // direction buttons
    assign pad.up    = held_reg[BTN_UP];
    assign pad.down  = held_reg[BTN_DOWN];
    assign pad.left  = held_reg[BTN_LEFT];
    assign pad.right = held_reg[BTN_RIGHT];

    btnq_dir u_dir (
        .pad       (pad),
        .dir_four  (dir4_w),
        .dir_eight (dir8_w)
    );

    // shared remainder unit for the repeat fold
    btnq_rem_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == ST_SCAN) && need_div),
        .dividend (e_upd),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign out_valid     = out_valid_reg;
    assign pressed_mask  = out_pm_reg;
    assign trigger_mask  = out_tm_reg;
    assign repeat_mask   = out_rm_reg;
    assign released_mask = out_fm_reg;
    assign dir_four      = out_d4_reg;
    assign dir_eight     = out_d8_reg;

endmodule

`default_nettype wire
